// ===== hdl/assert_macros.svh =====
// assertion helpers used by the lock unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge while out of reset
`define RMLU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// implication into the following cycle
`define RMLU_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/rmlu_pkg.sv =====
`default_nettype none

package rmlu_pkg;

    localparam int ACT_W = 3;
    localparam int TID_W = 8;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;

    // request codes
    localparam logic [ACT_W-1:0] ACT_LOCK       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_UNLOCK     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_WAIT       = 3'd2;
    localparam logic [ACT_W-1:0] ACT_NOTIFY     = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NOTIFY_ALL = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESUME = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NOTIFY = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] ST_PROCEED  = 2'd0;
    localparam logic [STAT_W-1:0] ST_BLOCKED  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ILLEGAL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_HAND,
        S_NOTE,
        S_STATUS
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/rmlu_queue_ram.sv =====
`default_nettype none

// simple dual port queue storage, one write and one registered read per cycle
module rmlu_queue_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== hdl/reentrant_monitor_lock_unit.sv =====
`default_nettype none

// channel  direction  handshake         word
// -------  ---------  ----------------  ------------------------------------------------
// request  in         i_valid/o_stall   i_action, i_thread_id
// result   out        o_valid/i_stall   o_kind, o_status, o_target_thread,
//                                       o_saved_count, o_last
//
// A request is taken in S_IDLE and decided in S_DECIDE, then each result word
// is loaded on its own in S_HAND, S_NOTE or S_STATUS while the result slot is free.
// Notify-all gives one pending-notify word per unstalled cycle from the waiter ram.
// Reset (i_rst_n low, synchronous) frees the monitor and empties both queues.
// A stalled result holds; the next request is taken while the last status waits.
module reentrant_monitor_lock_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [rmlu_pkg::ACT_W-1:0]    i_action,
    input  wire logic [rmlu_pkg::TID_W-1:0]    i_thread_id,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [rmlu_pkg::KIND_W-1:0]   o_kind,
    output logic      [rmlu_pkg::STAT_W-1:0]   o_status,
    output logic      [rmlu_pkg::TID_W-1:0]    o_target_thread,
    output logic      [COUNT_BITS-1:0]         o_saved_count,
    output logic                               o_last
);

`include "assert_macros.svh"

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int UW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = UW + 1;
    localparam int TW = rmlu_pkg::TID_W;
    localparam int WW = TW + COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [UW-1:0] USED_FULL = UW'(QUEUE_DEPTH);

    // head pointer step with wrap
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        r = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
        return r;
    endfunction

    // slot behind the last occupied one
    function automatic logic [AW-1:0] ptr_tail(input logic [AW-1:0] h, input logic [UW-1:0] u);
        logic [SW-1:0] s;
        logic [SW-1:0] w;
        s = SW'(h) + SW'(u);
        w = (s >= SW'(QUEUE_DEPTH)) ? s - SW'(QUEUE_DEPTH) : s;
        return w[AW-1:0];
    endfunction

    rmlu_pkg::t_state r_state, n_state;

    logic [rmlu_pkg::ACT_W-1:0]  r_action, n_action;
    logic [TW-1:0]               r_tid, n_tid;
    logic [rmlu_pkg::STAT_W-1:0] r_req_status, n_req_status;

    logic [TW-1:0]         r_owner_thread, n_owner_thread;
    logic                  r_owner_valid, n_owner_valid;
    logic [COUNT_BITS-1:0] r_hold_count, n_hold_count;
    logic [AW-1:0]         r_entry_head, n_entry_head;
    logic [UW-1:0]         r_entry_used, n_entry_used;
    logic [AW-1:0]         r_waiter_head, n_waiter_head;
    logic [UW-1:0]         r_waiter_used, n_waiter_used;

    logic                          r_o_valid, n_o_valid;
    logic [rmlu_pkg::KIND_W-1:0]   r_o_kind, n_o_kind;
    logic [rmlu_pkg::STAT_W-1:0]   r_o_status, n_o_status;
    logic [TW-1:0]                 r_o_target, n_o_target;
    logic [COUNT_BITS-1:0]         r_o_saved, n_o_saved;
    logic                          r_o_last, n_o_last;

    logic          ent_we;
    logic [AW-1:0] ent_waddr;
    logic [TW-1:0] ent_rdata;
    logic          wt_we;
    logic [AW-1:0] wt_waddr;
    logic [WW-1:0] wt_wdata;
    logic [WW-1:0] wt_rdata;
    logic          owns;
    logic          slot_free;
    logic [COUNT_BITS-1:0] count_dec;

    // entry queue storage, read at the head the next cycle will see
    rmlu_queue_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (TW)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (r_tid),
        .i_raddr (n_entry_head),
        .o_rdata (ent_rdata)
    );

    // waiter queue storage, thread and saved count side by side
    rmlu_queue_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (WW)
    ) u_waiter_ram (
        .i_clk   (i_clk),
        .i_we    (wt_we),
        .i_waddr (wt_waddr),
        .i_wdata (wt_wdata),
        .i_raddr (n_waiter_head),
        .o_rdata (wt_rdata)
    );

    assign owns      = r_owner_valid && (r_owner_thread == r_tid);
    assign slot_free = !r_o_valid || !i_stall;
    assign count_dec = r_hold_count - COUNT_BITS'(1);
    assign ent_waddr = ptr_tail(r_entry_head, r_entry_used);
    assign wt_waddr  = ptr_tail(r_waiter_head, r_waiter_used);
    assign wt_wdata  = {r_tid, r_hold_count};

    // request decode, queue bookkeeping and result word loading
    always_comb begin
        n_state        = r_state;
        n_action       = r_action;
        n_tid          = r_tid;
        n_req_status   = r_req_status;
        n_owner_thread = r_owner_thread;
        n_owner_valid  = r_owner_valid;
        n_hold_count   = r_hold_count;
        n_entry_head   = r_entry_head;
        n_entry_used   = r_entry_used;
        n_waiter_head  = r_waiter_head;
        n_waiter_used  = r_waiter_used;
        n_o_valid      = r_o_valid && i_stall;
        n_o_kind       = r_o_kind;
        n_o_status     = r_o_status;
        n_o_target     = r_o_target;
        n_o_saved      = r_o_saved;
        n_o_last       = r_o_last;
        ent_we         = 1'b0;
        wt_we          = 1'b0;

        unique case (r_state)
            rmlu_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_action = i_action;
                    n_tid    = i_thread_id;
                    n_state  = rmlu_pkg::S_DECIDE;
                end
            end

            rmlu_pkg::S_DECIDE: begin
                n_req_status = rmlu_pkg::ST_PROCEED;
                n_state      = rmlu_pkg::S_STATUS;
                unique case (r_action) inside
                    rmlu_pkg::ACT_LOCK: begin
                        if (!r_owner_valid) begin
                            n_owner_thread = r_tid;
                            n_owner_valid  = 1'b1;
                            n_hold_count   = COUNT_BITS'(1);
                        end else if (owns) begin
                            if (r_hold_count == COUNT_MAX) begin
                                n_req_status = rmlu_pkg::ST_OVERFLOW;
                            end else begin
                                n_hold_count = r_hold_count + COUNT_BITS'(1);
                            end
                        end else if (r_entry_used == USED_FULL) begin
                            n_req_status = rmlu_pkg::ST_OVERFLOW;
                        end else begin
                            ent_we       = 1'b1;
                            n_entry_used = r_entry_used + UW'(1);
                            n_req_status = rmlu_pkg::ST_BLOCKED;
                        end
                    end
                    rmlu_pkg::ACT_UNLOCK: begin
                        if (!owns) begin
                            n_req_status = rmlu_pkg::ST_ILLEGAL;
                        end else begin
                            n_hold_count = count_dec;
                            if (count_dec == '0) begin
                                n_owner_valid = 1'b0;
                                if (r_entry_used != '0) begin
                                    n_state = rmlu_pkg::S_HAND;
                                end
                            end
                        end
                    end
                    rmlu_pkg::ACT_WAIT: begin
                        if (!owns) begin
                            n_req_status = rmlu_pkg::ST_ILLEGAL;
                        end else if (r_waiter_used == USED_FULL) begin
                            n_req_status = rmlu_pkg::ST_OVERFLOW;
                        end else begin
                            wt_we         = 1'b1;
                            n_waiter_used = r_waiter_used + UW'(1);
                            n_hold_count  = '0;
                            n_owner_valid = 1'b0;
                            n_req_status  = rmlu_pkg::ST_BLOCKED;
                            if (r_entry_used != '0) begin
                                n_state = rmlu_pkg::S_HAND;
                            end
                        end
                    end
                    rmlu_pkg::ACT_NOTIFY, rmlu_pkg::ACT_NOTIFY_ALL: begin
                        if (!owns) begin
                            n_req_status = rmlu_pkg::ST_ILLEGAL;
                        end else if (r_waiter_used != '0) begin
                            n_state = rmlu_pkg::S_NOTE;
                        end
                    end
                    default: begin
                        n_req_status = rmlu_pkg::ST_ILLEGAL;
                    end
                endcase
            end

            // grant the monitor to the oldest blocked entrant
            rmlu_pkg::S_HAND: begin
                if (slot_free) begin
                    n_o_valid      = 1'b1;
                    n_o_kind       = rmlu_pkg::KIND_RESUME;
                    n_o_status     = rmlu_pkg::ST_PROCEED;
                    n_o_target     = ent_rdata;
                    n_o_saved      = COUNT_BITS'(1);
                    n_o_last       = 1'b0;
                    n_owner_thread = ent_rdata;
                    n_owner_valid  = 1'b1;
                    n_hold_count   = COUNT_BITS'(1);
                    n_entry_head   = ptr_inc(r_entry_head);
                    n_entry_used   = r_entry_used - UW'(1);
                    n_state        = rmlu_pkg::S_STATUS;
                end
            end

            // pending notify for the oldest waiter
            rmlu_pkg::S_NOTE: begin
                if (slot_free) begin
                    n_o_valid     = 1'b1;
                    n_o_kind      = rmlu_pkg::KIND_NOTIFY;
                    n_o_status    = rmlu_pkg::ST_PROCEED;
                    n_o_target    = wt_rdata[WW-1:COUNT_BITS];
                    n_o_saved     = wt_rdata[COUNT_BITS-1:0];
                    n_o_last      = 1'b0;
                    n_waiter_head = ptr_inc(r_waiter_head);
                    n_waiter_used = r_waiter_used - UW'(1);
                    if (r_action != rmlu_pkg::ACT_NOTIFY_ALL || r_waiter_used == UW'(1)) begin
                        n_state = rmlu_pkg::S_STATUS;
                    end
                end
            end

            // closing status word
            rmlu_pkg::S_STATUS: begin
                if (slot_free) begin
                    n_o_valid  = 1'b1;
                    n_o_kind   = rmlu_pkg::KIND_STATUS;
                    n_o_status = r_req_status;
                    n_o_target = r_tid;
                    n_o_saved  = '0;
                    n_o_last   = 1'b1;
                    n_state    = rmlu_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = rmlu_pkg::S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= rmlu_pkg::S_IDLE;
            r_owner_thread <= '0;
            r_owner_valid  <= 1'b0;
            r_hold_count   <= '0;
            r_entry_head   <= '0;
            r_entry_used   <= '0;
            r_waiter_head  <= '0;
            r_waiter_used  <= '0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_owner_thread <= n_owner_thread;
            r_owner_valid  <= n_owner_valid;
            r_hold_count   <= n_hold_count;
            r_entry_head   <= n_entry_head;
            r_entry_used   <= n_entry_used;
            r_waiter_head  <= n_waiter_head;
            r_waiter_used  <= n_waiter_used;
            r_o_valid      <= n_o_valid;
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_tid        <= n_tid;
        r_req_status <= n_req_status;
        r_o_kind     <= n_o_kind;
        r_o_status   <= n_o_status;
        r_o_target   <= n_o_target;
        r_o_saved    <= n_o_saved;
        r_o_last     <= n_o_last;
    end

    assign o_stall         = (r_state != rmlu_pkg::S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_kind          = r_o_kind;
    assign o_status        = r_o_status;
    assign o_target_thread = r_o_target;
    assign o_saved_count   = r_o_saved;
    assign o_last          = r_o_last;

    // checks
    `RMLU_ASSERT(a_entry_bound, r_entry_used <= USED_FULL, "entry queue overfilled")
    `RMLU_ASSERT(a_waiter_bound, r_waiter_used <= USED_FULL, "waiter queue overfilled")
    `RMLU_ASSERT(a_owner_count, r_owner_valid == (r_hold_count != '0),
        "owner flag and hold count disagree")
    `RMLU_ASSERT(a_hand_needs_entrant,
        r_state != rmlu_pkg::S_HAND || (r_entry_used != '0 && !r_owner_valid),
        "hand-off with no entrant or a held monitor")
    `RMLU_ASSERT_NEXT(a_status_ends, r_state == rmlu_pkg::S_STATUS && slot_free,
        r_state == rmlu_pkg::S_IDLE && o_valid && o_last, "status word did not end the request")

endmodule

`default_nettype wire
